FILE: src/osr_pkg.sv
// ----------------------------------------------------------------------------
// osr_pkg
// Shared constants and types for the operand stack with roll.
// ----------------------------------------------------------------------------
`default_nettype none

package osr_pkg;

    localparam int unsigned STACK_CAPACITY = 256;
    localparam int unsigned ADDR_W = (STACK_CAPACITY > 1) ? $clog2(STACK_CAPACITY) : 1;
    localparam int unsigned CNT_W  = $clog2(STACK_CAPACITY + 1);

    localparam logic [2:0] REQ_PUSH   = 3'd0;
    localparam logic [2:0] REQ_POP    = 3'd1;
    localparam logic [2:0] REQ_DROP   = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_INDEX  = 3'd4;
    localparam logic [2:0] REQ_EXCH   = 3'd5;
    localparam logic [2:0] REQ_ROLL   = 3'd6;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic CFG_MAX_DEPTH   = 1'b0;
    localparam logic CFG_CHECK_DEPTH = 1'b1;

    typedef logic [63:0] word_t;

    typedef struct packed {
        logic        we;
        logic [ADDR_W-1:0] waddr;
        word_t       wdata;
        logic        re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

FILE: src/osr_ram.sv
// ----------------------------------------------------------------------------
// osr_ram
// Single-port-write, single-port-read stack memory, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module osr_ram (
    input  wire logic             clk,
    input  wire osr_pkg::mem_req_t req,
    output osr_pkg::word_t        rdata
);
    import osr_pkg::*;

    word_t mem [STACK_CAPACITY];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/osr_divider.sv
// ----------------------------------------------------------------------------
// osr_divider
// Restoring remainder unit: one quotient bit per cycle, 17-bit dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module osr_divider (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [16:0]              dividend,
    input  wire logic [osr_pkg::CNT_W-1:0] divisor,
    output logic                          done,
    output logic [osr_pkg::CNT_W-1:0]     remainder
);
    import osr_pkg::*;

    localparam int unsigned REM_W = CNT_W + 1;

    logic [16:0]      quo_reg, quo_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[REM_W-2:0], quo_reg[16]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 5'd17;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[15:0], 1'b0};
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[CNT_W-1:0];

endmodule

`default_nettype wire

FILE: src/operand_stack_with_roll_unit.sv
// ----------------------------------------------------------------------------
// operand_stack_with_roll_unit
// Bounded 64-bit operand stack with push/pop/drop/clear/index/exch/roll.
// ----------------------------------------------------------------------------
// One item at a time. Push, drop, clear and failed requests finish in the
// execute state; pop and index make one memory read with registered data.
// Exchange makes two reads and two writes. Roll first reduces the shift
// with the 17-step remainder, then does a cycle-walk over the k entries,
// moving one entry at a time and reading anew to start each permutation
// cycle. Everything goes through one synchronous stack memory with one
// write and one read port; the rotation is done in place by following
// permutation cycles. The memory needs no clearing: entries above the
// depth are never read. A result waits in an output register until taken.
`default_nettype none

module operand_stack_with_roll_unit (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_index,
    input  wire logic [8:0]               cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [2:0]               req_type,
    input  wire logic [63:0]              push_value,
    input  wire logic [7:0]               position,
    input  wire logic [8:0]               block_count,
    input  wire logic signed [15:0]       roll_shift,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [1:0]                    status,
    output logic [63:0]                   read_value,
    output logic [8:0]                    depth_now
);
    import osr_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_EXEC   = 4'd1;
    localparam logic [3:0] S_RDWAIT = 4'd2;
    localparam logic [3:0] S_XRD2   = 4'd3;
    localparam logic [3:0] S_XWR    = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_RSTART = 4'd6;
    localparam logic [3:0] S_RREAD  = 4'd7;
    localparam logic [3:0] S_RMOVE  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    // configuration
    logic [8:0] max_depth_reg;
    logic       check_depth_reg;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // latched item
    logic [2:0]       req_reg;
    word_t            val_reg;
    logic [7:0]       pos_reg;
    logic [CNT_W-1:0] k_reg;
    logic             neg_reg;
    logic [16:0]      mag_reg;

    // output
    logic [1:0]       status_reg, status_next;
    word_t            rd_reg, rd_next;
    logic             ov_reg, ov_next;

    // exchange / roll working regs
    word_t            hold_reg, hold_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] start_reg, start_next;   // cycle start offset
    logic [CNT_W-1:0] cur_reg, cur_next;       // current offset in block
    logic [CNT_W-1:0] moved_reg, moved_next;   // entries placed

    mem_req_t mreq;
    word_t    mrdata;
    logic     div_start, div_done;
    logic [CNT_W-1:0] div_rem;

    osr_ram u_ram (
        .clk   (clk),
        .req   (mreq),
        .rdata (mrdata)
    );

    osr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (k_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // offset in block where the entry at offset o moves: (o+n) mod k
    function automatic logic [CNT_W-1:0] wrap_add(
        input logic [CNT_W-1:0] o, input logic [CNT_W-1:0] n,
        input logic [CNT_W-1:0] k);
        logic [CNT_W:0] s;
        begin
            s = {1'b0, o} + {1'b0, n};
            if (s >= {1'b0, k})
            begin
                s = s - {1'b0, k};
            end
            wrap_add = s[CNT_W-1:0];
        end
    endfunction

    logic [CNT_W-1:0] dst_off;
    logic [CNT_W-1:0] sum_addr;
    logic             push_full;

    assign dst_off  = wrap_add(cur_reg, n_reg, k_reg);
    assign in_ready = (state_reg == S_IDLE);
    assign push_full = (check_depth_reg && ({{(CNT_W+1-9){1'b0}}, max_depth_reg}
                        <= {1'b0, cnt_reg})) || (cnt_reg == CNT_W'(STACK_CAPACITY));
    assign sum_addr = base_reg + dst_off;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        ov_next     = ov_reg;
        hold_next   = hold_reg;
        n_next      = n_reg;
        base_next   = base_reg;
        start_next  = start_reg;
        cur_next    = cur_reg;
        moved_next  = moved_reg;
        div_start   = 1'b0;
        mreq        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                rd_next     = '0;
                state_next  = S_OUT;
                case (req_reg)
                    REQ_PUSH:
                    begin
                        if (push_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mreq.we    = 1'b1;
                            mreq.waddr = cnt_reg[ADDR_W-1:0];
                            mreq.wdata = val_reg;
                            cnt_next   = cnt_reg + 1'b1;
                        end
                    end
                    REQ_POP, REQ_DROP:
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            cnt_next = cnt_reg - 1'b1;
                            if (req_reg == REQ_POP)
                            begin
                                mreq.re    = 1'b1;
                                mreq.raddr = ADDR_W'(cnt_reg - 1'b1);
                                state_next = S_RDWAIT;
                            end
                        end
                    end
                    REQ_CLEAR:
                    begin
                        cnt_next = '0;
                    end
                    REQ_INDEX:
                    begin
                        if ({{(CNT_W-8){1'b0}}, pos_reg} >= cnt_reg)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mreq.re    = 1'b1;
                            mreq.raddr = ADDR_W'(cnt_reg - 1'b1
                                         - {{(CNT_W-8){1'b0}}, pos_reg});
                            state_next = S_RDWAIT;
                        end
                    end
                    REQ_EXCH:
                    begin
                        if (cnt_reg < CNT_W'(2))
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mreq.re    = 1'b1;
                            mreq.raddr = ADDR_W'(cnt_reg - 1'b1);
                            state_next = S_XRD2;
                        end
                    end
                    REQ_ROLL:
                    begin
                        if (k_reg > cnt_reg)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (k_reg != '0 && mag_reg != '0)
                        begin
                            div_start  = 1'b1;
                            base_next  = cnt_reg - k_reg;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RDWAIT:
            begin
                rd_next    = mrdata;
                state_next = S_OUT;
            end
            S_XRD2:
            begin
                // top word arrives; read the second
                hold_next  = mrdata;
                mreq.re    = 1'b1;
                mreq.raddr = ADDR_W'(cnt_reg - CNT_W'(2));
                state_next = S_XWR;
                moved_next = '0;
            end
            S_XWR:
            begin
                mreq.we = 1'b1;
                if (moved_reg == '0)
                begin
                    mreq.waddr = ADDR_W'(cnt_reg - 1'b1);
                    mreq.wdata = mrdata;
                    hold_next  = hold_reg;
                    moved_next = CNT_W'(1);
                    // write the second word to the top; hold keeps the top word for the second slot
                    rd_next    = '0;
                    n_next     = n_reg;
                end
                else
                begin
                    mreq.waddr = ADDR_W'(cnt_reg - CNT_W'(2));
                    mreq.wdata = hold_reg;
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        n_next     = neg_reg ? (k_reg - div_rem) : div_rem;
                        start_next = '0;
                        moved_next = '0;
                        state_next = S_RSTART;
                    end
                end
            end
            S_RSTART:
            begin
                // begin a permutation cycle at offset start_reg
                mreq.re    = 1'b1;
                mreq.raddr = ADDR_W'(base_reg + start_reg);
                cur_next   = start_reg;
                state_next = S_RREAD;
            end
            S_RREAD:
            begin
                // carried word in mrdata (from offset cur); read destination
                hold_next  = mrdata;
                mreq.re    = 1'b1;
                mreq.raddr = ADDR_W'(sum_addr);
                state_next = S_RMOVE;
            end
            S_RMOVE:
            begin
                // write carried word to destination, carry displaced word on
                mreq.we    = 1'b1;
                mreq.waddr = ADDR_W'(sum_addr);
                mreq.wdata = hold_reg;
                hold_next  = mrdata;
                cur_next   = dst_off;
                moved_next = moved_reg + 1'b1;
                if (moved_reg + 1'b1 == k_reg)
                begin
                    state_next = S_OUT;
                end
                else if (dst_off == start_reg)
                begin
                    start_next = start_reg + 1'b1;
                    state_next = S_RSTART;
                end
                else
                begin
                    mreq.re    = 1'b1;
                    mreq.raddr = ADDR_W'(base_reg + wrap_add(dst_off, n_reg, k_reg));
                    state_next = S_RMOVE;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (ov_reg && out_ready && !(state_reg == S_OUT))
        begin
            ov_next = 1'b0;
        end
    end

    // Note: the read-ahead in S_RMOVE returns the word at the next destination
    // in the following S_RMOVE, where hold already carries the word that
    // goes there. Since the first cycle entry (start) was read at its own
    // start, every later destination has not been overwritten yet.

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            ov_reg          <= 1'b0;
            max_depth_reg   <= 9'd256;
            check_depth_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_DEPTH:   max_depth_reg   <= cfg_data;
                    CFG_CHECK_DEPTH: check_depth_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rd_reg     <= rd_next;
        hold_reg   <= hold_next;
        n_reg      <= n_next;
        base_reg   <= base_next;
        start_reg  <= start_next;
        cur_reg    <= cur_next;
        moved_reg  <= moved_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            req_reg <= req_type;
            val_reg <= push_value;
            pos_reg <= position;
            k_reg   <= CNT_W'(block_count);
            neg_reg <= roll_shift[15];
            mag_reg <= roll_shift[15] ? (17'h10000 - {1'b0, roll_shift})
                                      : {1'b0, roll_shift};
        end
    end

    // result registers are copied into the output stage in S_OUT
    word_t      out_rd_reg;
    logic [1:0] out_st_reg;
    logic [8:0] out_dp_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!ov_reg || out_ready))
        begin
            out_rd_reg <= rd_reg;
            out_st_reg <= status_reg;
            out_dp_reg <= 9'(cnt_reg);
        end
    end

    assign out_valid  = ov_reg;
    assign status     = out_st_reg;
    assign read_value = out_rd_reg;
    assign depth_now  = out_dp_reg;

endmodule

`default_nettype wire

FILE: src/osr_checker.sv
// ----------------------------------------------------------------------------
// osr_checker
// Port-level checks for the operand stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

module osr_props (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [63:0] read_value,
    input wire logic [8:0]  depth_now
);
    import osr_pkg::*;

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_EMPTY))
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (read_value == 64'd0))
        else $error("failed item returned data");

    a_depth_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (depth_now <= 9'(STACK_CAPACITY)))
        else $error("depth beyond capacity");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(read_value)))
        else $error("result dropped while stalled");

    // one item at a time: the block is busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("item accepted while busy");

endmodule

bind operand_stack_with_roll_unit osr_props u_osr_props (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_value (read_value),
    .depth_now  (depth_now)
);

`default_nettype wire
